>>> hdl/vzs_pkg.sv
`timescale 1ns / 1ps

package vzs_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int SUM_W      = 38;
   localparam int DIFF_W     = 40;  // n*x - S, signed
   localparam int MAG_W      = 39;  // |n*x - S|
   localparam int SQ_W       = 84;  // sum of squared differences
   localparam int DIV_NUM_W  = 128;
   localparam int DIV_DEN_W  = 64;
   localparam int DIV_CNT_W  = 7;
   localparam int VAR_SHIFT  = 44;
   localparam int SCORE_SHIFT = 38;
   localparam int ROOT_W     = 64;
   localparam int SQREM_W    = 66;
   localparam int SQ_STEPS_W = 6;
   localparam int MUL_CNT_W  = 6;
   localparam int SCALE_W    = 81;

   localparam logic [SCALE_W-1:0] POS_LIMIT = SCALE_W'(64'h7FFF_FFFF);
   localparam logic [SCALE_W-1:0] NEG_LIMIT = SCALE_W'(64'h8000_0000);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] score;
      logic                       end_of_vector;
      logic                       overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_Q_RD,
      ST_Q_DIFF,
      ST_Q_MUL,
      ST_V_START,
      ST_V_WAIT,
      ST_SQRT,
      ST_E_RD,
      ST_E_DIFF,
      ST_E_START,
      ST_E_WAIT,
      ST_E_OUT
   } state_type;

endpackage

>>> hdl/vector_z_score_top.sv
`timescale 1ns / 1ps
// After the last-marked request, the deviation n*x - S of each stored sample is squared
//   by shift-add, then the shared divider gives the variance, a 64-step digit-by-digit
//   root follows, and each response takes one more divide by the root; with zero
//   deviation there is no emit divide. Throughput: one vector at a time; req_ready is
//   high only while collecting samples. Reset (synchronous, active high) clears the
//   count, sum, overflow flag, mode and sequencer; the sample store is not cleared.
module vector_z_score_top #(
   parameter int MAX_LEN = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  vzs_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output vzs_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_data
);
   import vzs_pkg::*;

   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int CNT_W = $clog2(MAX_LEN + 1);

   // sample store, undefined until written
   logic [SAMPLE_W-1:0] store [MAX_LEN];

   state_type state_ff, state_in;

   logic [CNT_W-1:0]         count_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic                     ovf_ff;
   logic                     kind_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic signed [DIFF_W-1:0] d_ff;
   logic [MAG_W-1:0]         ad_ff;
   logic [MAG_W-1:0]         mplier_ff;
   logic [SQ_W-1:0]          mcand_ff;
   logic [SQ_W-1:0]          q_ff;
   logic [MUL_CNT_W-1:0]     mulcnt_ff;
   logic                     zero_ff;
   logic [DIV_NUM_W-1:0]     v_ff;
   logic [SQREM_W-1:0]       sqrem_ff;
   logic [ROOT_W-1:0]        root_ff;
   logic [SQ_STEPS_W-1:0]    sqcnt_ff;
   rsp_payload_type          rsp_ff;

   // shared divider
   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   div_status_type       div_status;
   logic [DIV_NUM_W-1:0] div_quot;
   logic [DIV_DEN_W-1:0] div_rem;

   vzs_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .status (div_status),
      .quot   (div_quot),
      .rem    (div_rem)
   );

   // arithmetic helpers
   logic                     req_fire, rsp_fire;
   logic                     room;
   logic                     elem_last;
   logic [CNT_W-1:0]         k_val;
   logic signed [DIFF_W-1:0] d_calc;
   logic [DIFF_W-1:0]        ad_calc;
   logic signed [CNT_W:0]    n_signed;
   logic [SQREM_W-1:0]       sq_shift, sq_trial;
   logic                     sq_fits;
   logic [SQREM_W-1:0]       sqrem_in;
   logic [ROOT_W-1:0]        root_in;
   logic                     round_up;
   logic [SCALE_W-1:0]       mag;
   logic [SAMPLE_W-1:0]      mag32;
   logic signed [SAMPLE_W-1:0] score_calc;
   logic                     mul_done, sq_done;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign room      = count_ff < CNT_W'(MAX_LEN);
   assign elem_last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign k_val     = kind_ff ? count_ff : count_ff - CNT_W'(1);
   assign mul_done  = mulcnt_ff == MUL_CNT_W'(MAG_W - 1);
   assign sq_done   = sqcnt_ff == SQ_STEPS_W'(ROOT_W - 1);

   // config register, always accepted
   assign csr_ready = 1'b1;

   always_comb begin
      // d = n*x - S
      n_signed = $signed({1'b0, count_ff});
      d_calc   = DIFF_W'(n_signed) * DIFF_W'(rd_data_ff) - DIFF_W'(sum_ff);
      ad_calc  = d_calc[DIFF_W-1] ? DIFF_W'(-d_calc) : DIFF_W'(d_calc);

      // digit-by-digit root step
      sq_shift = {sqrem_ff[SQREM_W-3:0], v_ff[DIV_NUM_W-1 -: 2]};
      sq_trial = {root_ff, 2'b01};
      sq_fits  = sq_shift >= sq_trial;
      sqrem_in = sq_fits ? sq_shift - sq_trial : sq_shift;
      root_in  = {root_ff[ROOT_W-2:0], sq_fits};

      // round half away from zero, then saturate
      round_up = {1'b0, div_rem} + {1'b0, div_rem} >= {1'b0, root_ff};
      mag      = SCALE_W'(div_quot[SCALE_W-2:0]) + SCALE_W'(round_up);
      if (d_ff[DIFF_W-1]) begin
         mag32      = (mag > NEG_LIMIT) ? NEG_LIMIT[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
         score_calc = $signed(SAMPLE_W'(0) - mag32);
      end else begin
         mag32      = (mag > POS_LIMIT) ? POS_LIMIT[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
         score_calc = $signed(mag32);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_fire && req_data.last) state_in = ST_Q_RD;
         ST_Q_RD:    state_in = ST_Q_DIFF;
         ST_Q_DIFF:  state_in = ST_Q_MUL;
         ST_Q_MUL: begin
            if (mul_done) state_in = elem_last ? ST_V_START : ST_Q_RD;
         end
         ST_V_START: begin
            if (k_val == '0 || q_ff == '0) state_in = ST_E_RD;
            else state_in = ST_V_WAIT;
         end
         ST_V_WAIT:  if (div_status.done) state_in = ST_SQRT;
         ST_SQRT:    if (sq_done) state_in = ST_E_RD;
         ST_E_RD:    state_in = ST_E_DIFF;
         ST_E_DIFF:  state_in = ST_E_START;
         ST_E_START: state_in = zero_ff ? ST_E_OUT : ST_E_WAIT;
         ST_E_WAIT:  if (div_status.done) state_in = ST_E_OUT;
         ST_E_OUT: begin
            if (rsp_ready) state_in = elem_last ? ST_IDLE : ST_E_RD;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs and divider control
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      div_start = 1'b0;
      div_num   = {q_ff, VAR_SHIFT'(0)};
      div_den   = DIV_DEN_W'(k_val);
      unique case (state_ff)
         ST_IDLE:    req_ready = 1'b1;
         ST_V_START: div_start = !(k_val == '0 || q_ff == '0);
         ST_E_START: begin
            div_start = !zero_ff;
            div_num   = DIV_NUM_W'({ad_ff, SCORE_SHIFT'(0)});
            div_den   = root_ff;
         end
         ST_E_OUT:   rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (req_fire && room) store[count_ff[IDX_W-1:0]] <= req_data.sample;
      rd_data_ff <= $signed(store[idx_ff]);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
         kind_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) kind_ff <= csr_data;
         if (req_fire) begin
            if (room) begin
               count_ff <= count_ff + CNT_W'(1);
               sum_ff   <= sum_ff + SUM_W'(req_data.sample);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (state_ff == ST_E_OUT && rsp_fire && elem_last) begin
            count_ff <= '0;
            sum_ff   <= '0;
            ovf_ff   <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            idx_ff  <= '0;
            q_ff    <= '0;
            zero_ff <= 1'b0;
         end
         ST_Q_DIFF: begin
            mplier_ff <= ad_calc[MAG_W-1:0];
            mcand_ff  <= SQ_W'(ad_calc[MAG_W-1:0]);
            mulcnt_ff <= '0;
         end
         ST_Q_MUL: begin
            // shift-add squaring, one multiplier bit a cycle
            if (mplier_ff[0]) q_ff <= q_ff + mcand_ff;
            mplier_ff <= mplier_ff >> 1;
            mcand_ff  <= mcand_ff << 1;
            mulcnt_ff <= mulcnt_ff + MUL_CNT_W'(1);
            if (mul_done) idx_ff <= elem_last ? '0 : idx_ff + IDX_W'(1);
         end
         ST_V_START: begin
            if (k_val == '0 || q_ff == '0) zero_ff <= 1'b1;
         end
         ST_V_WAIT: begin
            v_ff     <= div_quot;
            sqrem_ff <= '0;
            root_ff  <= '0;
            sqcnt_ff <= '0;
         end
         ST_SQRT: begin
            v_ff     <= v_ff << 2;
            sqrem_ff <= sqrem_in;
            root_ff  <= root_in;
            sqcnt_ff <= sqcnt_ff + SQ_STEPS_W'(1);
            if (sq_done && root_in == '0) zero_ff <= 1'b1;
         end
         ST_E_DIFF: begin
            d_ff  <= d_calc;
            ad_ff <= ad_calc[MAG_W-1:0];
         end
         ST_E_START: begin
            rsp_ff.score         <= '0;
            rsp_ff.end_of_vector <= elem_last;
            rsp_ff.overflow      <= ovf_ff;
         end
         ST_E_WAIT: begin
            if (div_status.done) rsp_ff.score <= score_calc;
         end
         ST_E_OUT: begin
            if (rsp_ready && !elem_last) idx_ff <= idx_ff + IDX_W'(1);
         end
         default: begin
         end
      endcase
   end

   assign rsp_data = rsp_ff;

endmodule

>>> hdl/vzs_div.sv
`timescale 1ns / 1ps

module vzs_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [vzs_pkg::DIV_NUM_W-1:0]     num,
   input  logic [vzs_pkg::DIV_DEN_W-1:0]     den,
   output vzs_pkg::div_status_type           status,
   output logic [vzs_pkg::DIV_NUM_W-1:0]     quot,
   output logic [vzs_pkg::DIV_DEN_W-1:0]     rem
);
   import vzs_pkg::*;

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   // restoring step: one quotient bit a cycle
   always_comb begin
      trial  = {rem_ff, num_ff[DIV_NUM_W-1]};
      fits   = trial >= {1'b0, den_ff};
      rem_in = fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
      num_in = {num_ff[DIV_NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = num_ff;
   assign rem         = rem_ff;

endmodule
